FILE: src/mcbp_pkg.sv
// Shared types and codes for the multi-channel byte pipe.
// No dependencies; used by multi_channel_byte_pipe and the testbench.
package mcbp_pkg;

    // Command codes carried in the low bits of s_tdata
    typedef enum logic [2:0] {
        FN_CREATE  = 3'd0,
        FN_WRITE   = 3'd1,
        FN_READ    = 3'd2,
        FN_CLOSE   = 3'd3,
        FN_DESTROY = 3'd4
    } func_t;

    // Result status codes
    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_BAD     = 3'd1,
        STS_FULL    = 3'd2,
        STS_EMPTY   = 3'd3,
        STS_EOD     = 3'd4,
        STS_RCLOSED = 3'd5
    } status_t;

    // Command sequencer states
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_LOOKUP,
        SEQ_FETCH
    } seq_state_t;

    localparam logic [7:0] FIRST_ID = 8'd3;

    localparam int FUNC_W    = 3;
    localparam int ID_W      = 8;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int TDATA_W   = 24;

endpackage

FILE: src/mcbp_byte_store.sv
// Byte buffer memory for all pipes: one write port, one registered read port.
// No package dependencies.
module mcbp_byte_store #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/mcbp_ctrl_table.sv
// Per-pipe control table: pointers, fill count and open flags in a memory,
// plus an existence flag per pipe in flip-flops cleared by reset. No package use.
module mcbp_ctrl_table #(
    parameter int ENTRIES = 8,
    parameter int SLOT_W  = 3,
    parameter int WIDTH   = 27
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    output logic              rd_exists,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              wr_exists
);

    logic [WIDTH-1:0]   mem [ENTRIES];
    logic [ENTRIES-1:0] exists_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

    // Existence flag: entry contents are meaningless while it is clear
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            exists_reg <= '0;
            rd_exists  <= 1'b0;
        end else begin
            if (wr_en) begin
                exists_reg[wr_addr] <= wr_exists;
            end
            if (rd_en) begin
                rd_exists <= exists_reg[rd_addr];
            end
        end
    end

endmodule

FILE: src/multi_channel_byte_pipe.sv
// Top level of the multi-channel byte pipe: command sequencer and result register.
// Depends on mcbp_pkg, mcbp_ctrl_table and mcbp_byte_store.
//
// A set of NUM_PIPES byte pipes (ring buffers of PIPE_DEPTH bytes each), addressed
// by pipe identifiers 3 .. 3+NUM_PIPES-1. Each input transaction is one command
// (create, write byte, read byte, close an end, destroy) and yields exactly one
// result transaction carrying a status, the byte read and the pipe identifier.
// Full and empty pipes return would-block status codes instead of stalling.
// Commands are handled one at a time: a command is taken in SEQ_IDLE, its pipe
// entry is read from the control table into SEQ_LOOKUP, and the update is written
// back there once the output register is free; a read also passes through
// SEQ_FETCH for the byte store's registered read port before its result loads.
// A finished result sits in the output register; the next command is accepted
// while it waits, and only the write-back stalls if the register is still full.
// There is no clearing pass after reset: pipe existence flags reset in
// flip-flops and buffer bytes are only returned once written.
module multi_channel_byte_pipe #(
    parameter int NUM_PIPES  = 8,
    parameter int PIPE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Command channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [2:0] func, [10:3] pipe_id, [18:11] data_byte, zero pad
    input  logic [0:0]  s_tuser,   // [0] is_reader
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [2:0] status, [10:3] data_out, [18:11] pipe_id_out
);

    localparam int SLOT_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int PTR_W  = $clog2(PIPE_DEPTH);
    localparam int FILL_W = $clog2(PIPE_DEPTH + 1);
    localparam int STORE_DEPTH = NUM_PIPES * PIPE_DEPTH;
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CTRL_W = 2 * PTR_W + FILL_W + 2;

    typedef struct packed {
        logic [PTR_W-1:0]  rd_ptr;
        logic [PTR_W-1:0]  wr_ptr;
        logic [FILL_W-1:0] fill;
        logic              reader_open;
        logic              writer_open;
    } ctrl_entry_t;

    // ------------------------------------------------------------------
    // Command decode at the input
    // ------------------------------------------------------------------
    logic [mcbp_pkg::ID_W-1:0] in_id;
    logic [mcbp_pkg::ID_W:0]   in_offset;
    logic                      in_range;

    assign in_id     = s_tdata[10:3];
    assign in_offset = {1'b0, in_id} - {1'b0, mcbp_pkg::FIRST_ID};
    assign in_range  = (in_id >= mcbp_pkg::FIRST_ID) &&
                       (in_offset < (mcbp_pkg::ID_W + 1)'(NUM_PIPES));

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    mcbp_pkg::seq_state_t state_reg, state_next;

    logic [mcbp_pkg::FUNC_W-1:0] cmd_func_reg;
    logic [mcbp_pkg::ID_W-1:0]   cmd_id_reg;
    logic [mcbp_pkg::BYTE_W-1:0] cmd_byte_reg;
    logic                        cmd_rd_end_reg;
    logic                        cmd_range_reg;
    logic [SLOT_W-1:0]           cmd_slot_reg;

    logic                          m_tvalid_reg;
    logic [mcbp_pkg::STATUS_W-1:0] m_status_reg;
    logic [mcbp_pkg::BYTE_W-1:0]   m_data_reg;
    logic [mcbp_pkg::ID_W-1:0]     m_id_reg;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic              ctrl_rd_en;
    ctrl_entry_t       ctrl_rd_entry;
    logic              ctrl_rd_exists;
    logic              ctrl_wr_en;
    ctrl_entry_t       ctrl_wr_entry;
    logic              ctrl_wr_exists;

    logic              byte_wr_en;
    logic              byte_rd_en;
    logic [ADDR_W-1:0] byte_base;
    logic [ADDR_W-1:0] byte_wr_addr;
    logic [ADDR_W-1:0] byte_rd_addr;
    logic [7:0]        byte_rd_data;

    mcbp_ctrl_table #(
        .ENTRIES (NUM_PIPES),
        .SLOT_W  (SLOT_W),
        .WIDTH   (CTRL_W)
    ) u_ctrl_table (
        .clk       (aclk),
        .rst_n     (aresetn),
        .rd_en     (ctrl_rd_en),
        .rd_addr   (in_offset[SLOT_W-1:0]),
        .rd_data   (ctrl_rd_entry),
        .rd_exists (ctrl_rd_exists),
        .wr_en     (ctrl_wr_en),
        .wr_addr   (cmd_slot_reg),
        .wr_data   (ctrl_wr_entry),
        .wr_exists (ctrl_wr_exists)
    );

    // Pipe base address in the shared byte store
    assign byte_base    = ADDR_W'(cmd_slot_reg) * ADDR_W'(PIPE_DEPTH);
    assign byte_wr_addr = byte_base + ADDR_W'(ctrl_rd_entry.wr_ptr);
    assign byte_rd_addr = byte_base + ADDR_W'(ctrl_rd_entry.rd_ptr);

    mcbp_byte_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_byte_store (
        .clk     (aclk),
        .wr_en   (byte_wr_en),
        .wr_addr (byte_wr_addr),
        .wr_data (cmd_byte_reg),
        .rd_en   (byte_rd_en),
        .rd_addr (byte_rd_addr),
        .rd_data (byte_rd_data)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic                          out_free;
    logic                          out_load;
    logic [mcbp_pkg::STATUS_W-1:0] res_status;
    logic [mcbp_pkg::BYTE_W-1:0]   res_data;
    logic                          fill_zero;
    logic                          fill_full;
    logic [PTR_W-1:0]              wr_ptr_inc;
    logic [PTR_W-1:0]              rd_ptr_inc;

    // A result may be loaded when the output register is empty or draining now
    assign out_free  = !m_tvalid_reg || m_tready;
    assign fill_zero = (ctrl_rd_entry.fill == '0);
    assign fill_full = (ctrl_rd_entry.fill == FILL_W'(PIPE_DEPTH));

    // Ring pointer wrap
    assign wr_ptr_inc = (ctrl_rd_entry.wr_ptr == PTR_W'(PIPE_DEPTH - 1)) ?
                        '0 : ctrl_rd_entry.wr_ptr + PTR_W'(1);
    assign rd_ptr_inc = (ctrl_rd_entry.rd_ptr == PTR_W'(PIPE_DEPTH - 1)) ?
                        '0 : ctrl_rd_entry.rd_ptr + PTR_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mcbp_pkg::SEQ_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        ctrl_rd_en     = 1'b0;
        ctrl_wr_en     = 1'b0;
        ctrl_wr_entry  = ctrl_rd_entry;
        ctrl_wr_exists = ctrl_rd_exists;
        byte_wr_en     = 1'b0;
        byte_rd_en     = 1'b0;
        out_load       = 1'b0;
        res_status     = mcbp_pkg::STS_BAD;
        res_data       = '0;

        case (state_reg)
            mcbp_pkg::SEQ_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctrl_rd_en = 1'b1;
                    state_next = mcbp_pkg::SEQ_LOOKUP;
                end
            end

            mcbp_pkg::SEQ_LOOKUP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = mcbp_pkg::SEQ_IDLE;
                    if (cmd_range_reg) begin
                        case (cmd_func_reg)
                            mcbp_pkg::FN_CREATE: begin
                                res_status = mcbp_pkg::STS_OK;
                                // an existing pipe is left untouched
                                if (!ctrl_rd_exists) begin
                                    ctrl_wr_en                = 1'b1;
                                    ctrl_wr_exists            = 1'b1;
                                    ctrl_wr_entry.rd_ptr      = '0;
                                    ctrl_wr_entry.wr_ptr      = '0;
                                    ctrl_wr_entry.fill        = '0;
                                    ctrl_wr_entry.reader_open = 1'b1;
                                    ctrl_wr_entry.writer_open = 1'b1;
                                end
                            end
                            mcbp_pkg::FN_WRITE: begin
                                if (!ctrl_rd_exists) begin
                                    res_status = mcbp_pkg::STS_BAD;
                                end else if (!ctrl_rd_entry.reader_open) begin
                                    res_status = mcbp_pkg::STS_RCLOSED;
                                end else if (fill_full) begin
                                    res_status = mcbp_pkg::STS_FULL;
                                end else begin
                                    res_status           = mcbp_pkg::STS_OK;
                                    byte_wr_en           = 1'b1;
                                    ctrl_wr_en           = 1'b1;
                                    ctrl_wr_entry.wr_ptr = wr_ptr_inc;
                                    ctrl_wr_entry.fill   = ctrl_rd_entry.fill + FILL_W'(1);
                                end
                            end
                            mcbp_pkg::FN_READ: begin
                                if (!ctrl_rd_exists) begin
                                    res_status = mcbp_pkg::STS_BAD;
                                end else if (fill_zero) begin
                                    res_status = ctrl_rd_entry.writer_open ?
                                                 mcbp_pkg::STS_EMPTY : mcbp_pkg::STS_EOD;
                                end else begin
                                    // byte arrives next cycle; result loaded in SEQ_FETCH once the output is free
                                    out_load             = 1'b0;
                                    byte_rd_en           = 1'b1;
                                    ctrl_wr_en           = 1'b1;
                                    ctrl_wr_entry.rd_ptr = rd_ptr_inc;
                                    ctrl_wr_entry.fill   = ctrl_rd_entry.fill - FILL_W'(1);
                                    state_next           = mcbp_pkg::SEQ_FETCH;
                                end
                            end
                            mcbp_pkg::FN_CLOSE: begin
                                if (!ctrl_rd_exists) begin
                                    res_status = mcbp_pkg::STS_BAD;
                                end else begin
                                    res_status = mcbp_pkg::STS_OK;
                                    ctrl_wr_en = 1'b1;
                                    if (cmd_rd_end_reg) begin
                                        ctrl_wr_entry.reader_open = 1'b0;
                                    end else begin
                                        ctrl_wr_entry.writer_open = 1'b0;
                                    end
                                    // both ends closed destroys the pipe
                                    ctrl_wr_exists = ctrl_wr_entry.reader_open ||
                                                     ctrl_wr_entry.writer_open;
                                end
                            end
                            mcbp_pkg::FN_DESTROY: begin
                                if (!ctrl_rd_exists) begin
                                    res_status = mcbp_pkg::STS_BAD;
                                end else begin
                                    res_status     = mcbp_pkg::STS_OK;
                                    ctrl_wr_en     = 1'b1;
                                    ctrl_wr_exists = 1'b0;
                                end
                            end
                            default: begin
                                res_status = mcbp_pkg::STS_BAD;
                            end
                        endcase
                    end
                end
            end

            mcbp_pkg::SEQ_FETCH: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    res_status = mcbp_pkg::STS_OK;
                    res_data   = byte_rd_data;
                    state_next = mcbp_pkg::SEQ_IDLE;
                end
            end

            default: begin
                state_next = mcbp_pkg::SEQ_IDLE;
            end
        endcase
    end

    // Command capture
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_func_reg   <= s_tdata[2:0];
            cmd_id_reg     <= in_id;
            cmd_byte_reg   <= s_tdata[18:11];
            cmd_rd_end_reg <= s_tuser[0];
            cmd_range_reg  <= in_range;
            cmd_slot_reg   <= in_offset[SLOT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= res_status;
            m_data_reg   <= res_data;
            m_id_reg     <= cmd_id_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, m_id_reg, m_data_reg, m_status_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_to_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == mcbp_pkg::SEQ_LOOKUP) && !s_tready)
        else $error("accepted command did not move to lookup");

    a_fetch_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_rd_en |=> (state_reg == mcbp_pkg::SEQ_FETCH))
        else $error("byte store read not followed by fetch");

    a_fetch_result_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mcbp_pkg::SEQ_FETCH && out_free) |=>
        (m_tvalid && m_status_reg == mcbp_pkg::STS_OK))
        else $error("fetched byte not delivered with ok status");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_wr_en |-> (ctrl_wr_entry.fill <= FILL_W'(PIPE_DEPTH)))
        else $error("fill count above pipe depth");

    a_no_load_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !out_load)
        else $error("result overwritten while waiting");

endmodule

FILE: tb/tb_multi_channel_byte_pipe.sv
// Testbench for multi_channel_byte_pipe: directed and random command streams on the
// slave channel, each result checked against an in-bench model of the pipe set.
// Depends on mcbp_pkg and the RTL under src/.
module tb_multi_channel_byte_pipe;
    timeunit 1ns;
    timeprecision 1ps;

    import mcbp_pkg::*;

    localparam int NUM_PIPES  = 8;
    localparam int PIPE_DEPTH = 256;
    localparam int IDLE_PCT   = 22;
    localparam int LAST_ID    = int'(FIRST_ID) + NUM_PIPES - 1;

    // One expected result transaction
    typedef struct {
        status_t    status;
        logic [7:0] data;
        logic [7:0] id;
    } pipe_result_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // [2:0] func, [10:3] pipe_id, [18:11] data_byte, zero pad
    logic [0:0]  s_tuser  = '0;   // [0] is_reader
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [2:0] status, [10:3] data_out, [18:11] pipe_id_out

    multi_channel_byte_pipe #(
        .NUM_PIPES (NUM_PIPES),
        .PIPE_DEPTH(PIPE_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Pipe set mirror: ring buffers plus per-pipe control entries
    logic [7:0] ring_mem [NUM_PIPES][PIPE_DEPTH];
    int         rd_ptr   [NUM_PIPES];
    int         wr_ptr   [NUM_PIPES];
    int         fill     [NUM_PIPES];
    bit         exists   [NUM_PIPES];
    bit         r_open   [NUM_PIPES];
    bit         w_open   [NUM_PIPES];

    pipe_result_t pending_results[$];

    int n_errors   = 0;
    int n_sent     = 0;
    int n_seen     = 0;
    bit src_calm   = 1'b0;   // sender offers back to back
    bit sink_calm  = 1'b0;   // receiver always ready
    int sink_hold  = 0;      // cycles left in a forced receiver stall

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int ring_next(int p);
        return (p + 1 >= PIPE_DEPTH) ? 0 : p + 1;
    endfunction

    // Applies one command to the mirror and returns the result it must produce
    function automatic pipe_result_t pipe_apply(logic [2:0] fn, logic [7:0] id,
                                                logic [7:0] wbyte, logic rd_end);
        pipe_result_t r;
        int s;
        r.status = STS_BAD;
        r.data   = '0;
        r.id     = id;
        s        = int'(id) - int'(FIRST_ID);
        if (id >= FIRST_ID && s < NUM_PIPES && fn <= FN_DESTROY) begin
            if (fn == FN_CREATE) begin
                if (!exists[s]) begin
                    exists[s] = 1'b1;
                    rd_ptr[s] = 0;
                    wr_ptr[s] = 0;
                    fill[s]   = 0;
                    r_open[s] = 1'b1;
                    w_open[s] = 1'b1;
                end
                r.status = STS_OK;
            end else if (!exists[s]) begin
                r.status = STS_BAD;
            end else if (fn == FN_WRITE) begin
                if (!r_open[s]) begin
                    r.status = STS_RCLOSED;
                end else if (fill[s] >= PIPE_DEPTH) begin
                    r.status = STS_FULL;
                end else begin
                    ring_mem[s][wr_ptr[s]] = wbyte;
                    wr_ptr[s] = ring_next(wr_ptr[s]);
                    fill[s]++;
                    r.status = STS_OK;
                end
            end else if (fn == FN_READ) begin
                if (fill[s] == 0) begin
                    r.status = w_open[s] ? STS_EMPTY : STS_EOD;
                end else begin
                    r.data    = ring_mem[s][rd_ptr[s]];
                    rd_ptr[s] = ring_next(rd_ptr[s]);
                    fill[s]--;
                    r.status  = STS_OK;
                end
            end else if (fn == FN_CLOSE) begin
                if (rd_end)
                    r_open[s] = 1'b0;
                else
                    w_open[s] = 1'b0;
                if (!r_open[s] && !w_open[s])
                    exists[s] = 1'b0;
                r.status = STS_OK;
            end else begin
                exists[s] = 1'b0;
                r.status  = STS_OK;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got, want);
        n_errors++;
    endtask

    // Offers one command transaction; valid stays high after acceptance so the
    // next call can stream on without a bubble.
    task automatic send_cmd(logic [2:0] fn, logic [7:0] id, logic [7:0] wbyte = 8'h00,
                            logic rd_end = 1'b0);
        while (!src_calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, wbyte, id, fn};
        s_tuser  <= rd_end;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_results.push_back(pipe_apply(fn, id, wbyte, rd_end));
        n_sent++;
    endtask

    // Sender pause: drop valid and wait for every outstanding result
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Receiver: random stalls, a counted long stall on request
    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= sink_calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Result checker: every accepted result against the oldest expectation
    always @(posedge aclk) begin
        pipe_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", int'(m_tdata), 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[2:0] !== want.status)
                    report_mismatch("status", int'(m_tdata[2:0]), int'(want.status));
                if (m_tdata[10:3] !== want.data)
                    report_mismatch("data_out", int'(m_tdata[10:3]), int'(want.data));
                if (m_tdata[18:11] !== want.id)
                    report_mismatch("pipe_id_out", int'(m_tdata[18:11]), int'(want.id));
                if (m_tdata[23:19] !== 5'b0)
                    report_mismatch("tdata pad", int'(m_tdata[23:19]), 0);
            end
        end
    end

    // Identifiers below the first pipe and past the last one
    task automatic test_bad_ids();
        send_cmd(FN_CREATE, 8'd0);
        send_cmd(FN_WRITE, FIRST_ID - 8'd1, 8'h5A);
        send_cmd(FN_READ, 8'(LAST_ID + 1));
        send_cmd(FN_CLOSE, 8'hFF, 8'h00, 1'b1);
        wait_drain();
    endtask

    // Commands on pipes that were never created
    task automatic test_absent_pipe();
        send_cmd(FN_WRITE, FIRST_ID, 8'hFF);
        send_cmd(FN_READ, FIRST_ID);
        send_cmd(FN_CLOSE, FIRST_ID, 8'h00, 1'b0);
        send_cmd(FN_DESTROY, FIRST_ID);
        wait_drain();
    endtask

    // Create, repeat create, spare codes, empty / end of data, close both ends
    task automatic test_lifecycle();
        send_cmd(FN_CREATE, FIRST_ID);
        send_cmd(FN_CREATE, FIRST_ID);
        for (int f = int'(FN_DESTROY) + 1; f < 8; f++)
            send_cmd(3'(f), FIRST_ID, 8'h33);
        send_cmd(FN_WRITE, FIRST_ID, 8'h00);
        send_cmd(FN_WRITE, FIRST_ID, 8'hFF);
        send_cmd(FN_READ, FIRST_ID);
        send_cmd(FN_READ, FIRST_ID);
        send_cmd(FN_READ, FIRST_ID);                    // empty, writer open
        send_cmd(FN_CLOSE, FIRST_ID, 8'h00, 1'b0);
        send_cmd(FN_READ, FIRST_ID);                    // end of data
        send_cmd(FN_WRITE, FIRST_ID, 8'hAA);            // writer closed, still allowed
        send_cmd(FN_READ, FIRST_ID);
        send_cmd(FN_CLOSE, FIRST_ID, 8'h00, 1'b0);      // already closed
        send_cmd(FN_CLOSE, FIRST_ID, 8'h00, 1'b1);      // both closed: pipe gone
        send_cmd(FN_WRITE, FIRST_ID, 8'h11);
        wait_drain();
    endtask

    // Writes refused once the reader end is closed, then destroy
    task automatic test_reader_closed();
        send_cmd(FN_CREATE, 8'(LAST_ID));
        send_cmd(FN_CLOSE, 8'(LAST_ID), 8'h00, 1'b1);
        send_cmd(FN_WRITE, 8'(LAST_ID), 8'h77);
        send_cmd(FN_DESTROY, 8'(LAST_ID));
        wait_drain();
    endtask

    // Fill one pipe to capacity, overflow, drain past empty, then wrap pointers
    task automatic test_full_pipe();
        logic [7:0] pid;
        pid = FIRST_ID + 8'd1;
        send_cmd(FN_CREATE, pid);
        for (int i = 0; i < PIPE_DEPTH; i++)
            send_cmd(FN_WRITE, pid, 8'($urandom_range(255)));
        send_cmd(FN_WRITE, pid, 8'h99);                 // full
        for (int i = 0; i <= PIPE_DEPTH; i++)
            send_cmd(FN_READ, pid);                     // last one empty
        for (int i = 0; i < 4; i++)
            send_cmd(FN_WRITE, pid, 8'($urandom_range(255)));
        for (int i = 0; i < 4; i++)
            send_cmd(FN_READ, pid);
        send_cmd(FN_DESTROY, pid);
        wait_drain();
    endtask

    // Mostly well-formed traffic on a few pipes, a slice of noise
    task automatic send_random_cmd();
        int         pick;
        int         s;
        logic [2:0] fn;
        logic [7:0] id;
        pick = $urandom_range(99);
        s    = ($urandom_range(9) == 0) ? $urandom_range(NUM_PIPES - 1) : $urandom_range(3);
        id   = FIRST_ID + 8'(s);
        if (pick < 6)       fn = FN_CREATE;
        else if (pick < 44) fn = FN_WRITE;
        else if (pick < 80) fn = FN_READ;
        else if (pick < 88) fn = FN_CLOSE;
        else if (pick < 92) fn = FN_DESTROY;
        else begin
            fn = 3'($urandom_range(7));
            id = 8'($urandom_range(255));
        end
        // keep most traffic on live pipes so reads and writes get past the checks
        if (pick < 92 && !exists[s] && $urandom_range(99) < 75)
            fn = FN_CREATE;
        send_cmd(fn, id, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // A stretch with no idling on either side
    task automatic test_streaming();
        src_calm  = 1'b1;
        sink_calm = 1'b1;
        repeat (20) send_random_cmd();
        wait_drain();
        src_calm  = 1'b0;
        sink_calm = 1'b0;
    endtask

    // Receiver stalls for a long time while the sender keeps offering
    task automatic test_backpressure();
        sink_hold = 80;
        src_calm  = 1'b1;
        repeat (20) send_random_cmd();
        src_calm  = 1'b0;
        wait_drain();
    endtask

    task automatic test_random_mix();
        repeat (25) send_random_cmd();
        wait_drain();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_bad_ids();
        test_absent_pipe();
        test_lifecycle();
        test_reader_closed();
        test_full_pipe();
        test_streaming();
        test_backpressure();
        test_random_mix();

        repeat (10) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch("results never arrived", pending_results.size(), 0);

        $display("%0d commands sent, %0d results checked, %0d mismatches", n_sent, n_seen,
                 n_errors);
        $display("covered: bad ids, absent pipes, spare codes, full/empty/end of data,");
        $display("  close and destroy, pointer wrap, back-to-back and stalled traffic");
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("timeout: %0d results still outstanding", pending_results.size());
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: multi_channel_byte_pipe.f
src/mcbp_pkg.sv
src/mcbp_byte_store.sv
src/mcbp_ctrl_table.sv
src/multi_channel_byte_pipe.sv
tb/tb_multi_channel_byte_pipe.sv
